>>> rtl/timestamped_ring_buffer_defines.svh
// Assertion macros used by the checker of the ring buffer.
// Both macros expect clk and rst_n in scope.
`ifndef TIMESTAMPED_RING_BUFFER_DEFINES_SVH
`define TIMESTAMPED_RING_BUFFER_DEFINES_SVH

// Check that a condition always implies another in the same cycle
`define TRB_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition never occurs
`define TRB_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/trb_pkg.sv
package trb_pkg;

    localparam int CAPACITY    = 16;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int OCC_W       = $clog2(CAPACITY + 1);
    localparam int TIME_W      = 64;
    localparam int CAM_W       = 16;
    localparam int FRAME_W     = 32;
    localparam int OP_W        = 3;
    localparam int FILL_W      = 5;
    localparam int KIND_W      = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [OCC_W-1:0]  occ_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [OP_W-1:0]   op_t;

    // Opcodes seen on the request port
    localparam op_t OP_PUSH       = 3'd0;
    localparam op_t OP_POP_OLDEST = 3'd1;
    localparam op_t OP_POP_BEFORE = 3'd2;
    localparam op_t OP_POP_LATEST = 3'd3;
    localparam op_t OP_RANGE      = 3'd4;
    localparam op_t OP_CLEAR      = 3'd5;

    // Classified command kinds passed from front to back
    localparam kind_t KIND_PUSH       = 3'd0;
    localparam kind_t KIND_POP_OLD    = 3'd1;
    localparam kind_t KIND_POP_BEFORE = 3'd2;
    localparam kind_t KIND_POP_NEW    = 3'd3;
    localparam kind_t KIND_RANGE      = 3'd4;
    localparam kind_t KIND_CLEAR      = 3'd5;
    localparam kind_t KIND_NOP        = 3'd6;

    typedef struct packed {
        logic [TIME_W-1:0]  tstamp;
        logic [CAM_W-1:0]   camera;
        logic [FRAME_W-1:0] frame;
    } rec_t;

    typedef struct packed {
        kind_t              kind;
        logic [TIME_W-1:0]  key;
        logic [TIME_W-1:0]  rend;
        logic [CAM_W-1:0]   camera;
        logic [FRAME_W-1:0] frame;
    } cmd_t;

    function automatic idx_t next_idx(idx_t i);
        return (i == IDX_W'(CAPACITY - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic idx_t prev_idx(idx_t i);
        return (i == '0) ? IDX_W'(CAPACITY - 1) : i - 1'b1;
    endfunction

endpackage

>>> rtl/trb_front.sv
module trb_front
    import trb_pkg::*;
(
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    opcode,
    input  logic [TIME_W-1:0]  key_time,
    input  logic [TIME_W-1:0]  range_end,
    input  logic [CAM_W-1:0]   camera_tag,
    input  logic [FRAME_W-1:0] frame_number,
    input  logic               q_full,
    output logic               q_push,
    output cmd_t               q_cmd
);

    kind_t kind;

    // Map the opcode to a command kind; a zero bound turns pop-before into pop-oldest
    always_comb
    begin
        unique case (opcode)
            OP_PUSH:       kind = KIND_PUSH;
            OP_POP_OLDEST: kind = KIND_POP_OLD;
            OP_POP_BEFORE: kind = (key_time == '0) ? KIND_POP_OLD : KIND_POP_BEFORE;
            OP_POP_LATEST: kind = KIND_POP_NEW;
            OP_RANGE:      kind = KIND_RANGE;
            OP_CLEAR:      kind = KIND_CLEAR;
            default:       kind = KIND_NOP;
        endcase
    end

    // Accept a request whenever the queue has room
    assign busy   = q_full;
    assign q_push = start && !q_full;

    assign q_cmd.kind   = kind;
    assign q_cmd.key    = key_time;
    assign q_cmd.rend   = range_end;
    assign q_cmd.camera = camera_tag;
    assign q_cmd.frame  = frame_number;

endmodule

>>> rtl/trb_cmd_queue.sv
module trb_cmd_queue
    import trb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty,
    output logic full
);

    cmd_t              slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] bump(logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign empty    = (cnt_reg == '0);
    assign full     = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_cmd = slot[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/trb_back.sv
module trb_back
    import trb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  cmd_t               q_head,
    output logic               q_pop,
    output logic               result_valid,
    output logic               found,
    output logic [TIME_W-1:0]  out_time,
    output logic [CAM_W-1:0]   out_camera,
    output logic [FRAME_W-1:0] out_frame,
    output logic               last,
    output logic [FILL_W-1:0]  fill_count,
    output logic [TIME_W-1:0]  oldest_time,
    output logic [TIME_W-1:0]  latest_time
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_FETCH   = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_FLUSH   = 3'd3;
    localparam logic [2:0] S_REF_OLD = 3'd4;
    localparam logic [2:0] S_REF_NEW = 3'd5;
    localparam logic [2:0] S_REF_END = 3'd6;

    // Record memory, one write and one registered read per cycle
    rec_t mem [CAPACITY];
    rec_t rd_data_reg;
    idx_t rd_addr;
    logic mem_we;

    logic [2:0]        state_reg, state_next;
    idx_t              rp_reg, rp_next;
    idx_t              wp_reg, wp_next;
    occ_t              occ_reg, occ_next;
    cmd_t              cur_reg, cur_next;
    logic [TIME_W-1:0] oldest_reg, oldest_next;
    logic [TIME_W-1:0] latest_reg, latest_next;
    rec_t              hold_rec_reg, hold_rec_next;
    logic              pend_valid_reg, pend_valid_next;
    rec_t              pend_rec_reg, pend_rec_next;
    idx_t              scan_idx_reg, scan_idx_next;
    occ_t              scan_cnt_reg, scan_cnt_next;

    logic              res_valid_reg;
    logic              res_found_reg;
    rec_t              res_rec_reg;
    logic              res_last_reg;
    logic [FILL_W-1:0] res_fill_reg;
    logic [TIME_W-1:0] res_old_reg;
    logic [TIME_W-1:0] res_new_reg;

    logic              emit_en;
    logic              emit_found;
    rec_t              emit_rec;
    logic              emit_last;
    occ_t              emit_occ;
    logic [TIME_W-1:0] emit_old;
    logic [TIME_W-1:0] emit_new;

    logic before_hit;
    logic range_hit;
    logic first_elem;
    logic last_elem;

    // Compare the record read in the previous cycle against the request bounds
    assign before_hit = (rd_data_reg.tstamp <= cur_reg.key);
    assign range_hit  = (rd_data_reg.tstamp >= cur_reg.key) &&
                        (rd_data_reg.tstamp <= cur_reg.rend);
    assign first_elem = (scan_cnt_reg == OCC_W'(1));
    assign last_elem  = (scan_cnt_reg == occ_reg);

    always_comb
    begin
        state_next      = state_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        occ_next        = occ_reg;
        cur_next        = cur_reg;
        oldest_next     = oldest_reg;
        latest_next     = latest_reg;
        hold_rec_next   = hold_rec_reg;
        pend_valid_next = pend_valid_reg;
        pend_rec_next   = pend_rec_reg;
        scan_idx_next   = scan_idx_reg;
        scan_cnt_next   = scan_cnt_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        rd_addr         = rp_reg;
        emit_en         = 1'b0;
        emit_found      = 1'b0;
        emit_rec        = '0;
        emit_last       = 1'b1;
        emit_occ        = occ_reg;
        emit_old        = oldest_reg;
        emit_new        = latest_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cur_next = q_head;
                    unique case (q_head.kind) inside
                        KIND_PUSH:
                        begin
                            // Write at the newest end, drop the oldest when full
                            mem_we  = 1'b1;
                            wp_next = next_idx(wp_reg);
                            if (occ_reg == OCC_W'(CAPACITY))
                            begin
                                rp_next = next_idx(rp_reg);
                            end
                            else
                            begin
                                occ_next = occ_reg + 1'b1;
                            end
                            hold_rec_next = '0;
                            state_next    = S_REF_OLD;
                        end
                        KIND_POP_OLD, KIND_POP_NEW:
                        begin
                            if (occ_reg == '0)
                            begin
                                emit_en = 1'b1;
                            end
                            else
                            begin
                                rd_addr    = (q_head.kind == KIND_POP_NEW) ?
                                             prev_idx(wp_reg) : rp_reg;
                                state_next = S_FETCH;
                            end
                        end
                        KIND_POP_BEFORE, KIND_RANGE:
                        begin
                            if (occ_reg == '0)
                            begin
                                emit_en = 1'b1;
                            end
                            else
                            begin
                                rd_addr         = rp_reg;
                                scan_idx_next   = next_idx(rp_reg);
                                scan_cnt_next   = OCC_W'(1);
                                pend_valid_next = 1'b0;
                                state_next      = S_SCAN;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            rp_next    = '0;
                            wp_next    = '0;
                            occ_next   = '0;
                            emit_en    = 1'b1;
                            emit_found = 1'b1;
                            emit_occ   = '0;
                        end
                        default:
                        begin
                            emit_en = 1'b1;
                        end
                    endcase
                end
            end

            S_FETCH:
            begin
                // Remove the record just read from its end of the ring
                hold_rec_next = rd_data_reg;
                if (cur_reg.kind == KIND_POP_NEW)
                begin
                    wp_next = prev_idx(wp_reg);
                end
                else
                begin
                    rp_next = next_idx(rp_reg);
                end
                occ_next = occ_reg - 1'b1;
                if (occ_reg == OCC_W'(1))
                begin
                    emit_en    = 1'b1;
                    emit_found = 1'b1;
                    emit_rec   = rd_data_reg;
                    emit_occ   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_REF_OLD;
                end
            end

            S_SCAN:
            begin
                // Read ahead one record while checking the current one
                rd_addr       = scan_idx_reg;
                scan_idx_next = next_idx(scan_idx_reg);
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (cur_reg.kind == KIND_POP_BEFORE)
                begin
                    if (before_hit)
                    begin
                        if (first_elem)
                        begin
                            rp_next  = next_idx(rp_reg);
                            occ_next = occ_reg - 1'b1;
                            if (occ_reg == OCC_W'(1))
                            begin
                                emit_en    = 1'b1;
                                emit_found = 1'b1;
                                emit_rec   = rd_data_reg;
                                emit_occ   = '0;
                                state_next = S_IDLE;
                            end
                            else
                            begin
                                hold_rec_next = rd_data_reg;
                                state_next    = S_REF_OLD;
                            end
                        end
                        else
                        begin
                            emit_en    = 1'b1;
                            emit_found = 1'b1;
                            emit_rec   = rd_data_reg;
                            state_next = S_IDLE;
                        end
                    end
                    else if (last_elem)
                    begin
                        emit_en    = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    // Hold each match back one step so the final one carries last
                    if (range_hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            emit_en    = 1'b1;
                            emit_found = 1'b1;
                            emit_rec   = pend_rec_reg;
                            emit_last  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_rec_next   = rd_data_reg;
                    end
                    if (last_elem)
                    begin
                        state_next = S_FLUSH;
                    end
                end
            end

            S_FLUSH:
            begin
                emit_en    = 1'b1;
                emit_found = pend_valid_reg;
                emit_rec   = pend_valid_reg ? pend_rec_reg : '0;
                state_next = S_IDLE;
            end

            S_REF_OLD:
            begin
                rd_addr    = rp_reg;
                state_next = S_REF_NEW;
            end

            S_REF_NEW:
            begin
                oldest_next = rd_data_reg.tstamp;
                rd_addr     = prev_idx(wp_reg);
                state_next  = S_REF_END;
            end

            S_REF_END:
            begin
                latest_next = rd_data_reg.tstamp;
                emit_en     = 1'b1;
                emit_found  = 1'b1;
                emit_rec    = hold_rec_reg;
                emit_old    = oldest_reg;
                emit_new    = rd_data_reg.tstamp;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Write the pushed record, read one record per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= '{tstamp: q_head.key, camera: q_head.camera, frame: q_head.frame};
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rp_reg         <= '0;
            wp_reg         <= '0;
            occ_reg        <= '0;
            pend_valid_reg <= 1'b0;
            scan_idx_reg   <= '0;
            scan_cnt_reg   <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            occ_reg        <= occ_next;
            pend_valid_reg <= pend_valid_next;
            scan_idx_reg   <= scan_idx_next;
            scan_cnt_reg   <= scan_cnt_next;
            res_valid_reg  <= emit_en;
        end
    end

    // Hold request data, cached end times and the result being sent
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        oldest_reg   <= oldest_next;
        latest_reg   <= latest_next;
        hold_rec_reg <= hold_rec_next;
        pend_rec_reg <= pend_rec_next;
        if (emit_en)
        begin
            res_found_reg <= emit_found;
            res_rec_reg   <= emit_rec;
            res_last_reg  <= emit_last;
            res_fill_reg  <= FILL_W'(emit_occ);
            res_old_reg   <= (emit_occ == '0) ? '0 : emit_old;
            res_new_reg   <= (emit_occ == '0) ? '0 : emit_new;
        end
    end

    assign result_valid = res_valid_reg;
    assign found        = res_found_reg;
    assign out_time     = res_rec_reg.tstamp;
    assign out_camera   = res_rec_reg.camera;
    assign out_frame    = res_rec_reg.frame;
    assign last         = res_last_reg;
    assign fill_count   = res_fill_reg;
    assign oldest_time  = res_old_reg;
    assign latest_time  = res_new_reg;

endmodule

>>> rtl/timestamped_ring_buffer.sv
// Ring of 16 timestamped frame records. A request is taken at a rising edge with
// start high and busy low; up to two requests wait in a queue ahead of the engine,
// and busy is high while that queue is full. Results cannot be held off: each one
// shows for a single cycle with result_valid high, and last marks the final result
// of a request. The engine reads the record memory through one port, one record per
// cycle, and every change to the ring that leaves it non-empty costs two more reads
// to refresh the oldest and latest times. A push writes and refreshes; pop-oldest
// and pop-latest read their record, then refresh unless the ring is left empty;
// clear, unused opcodes and any pop or range query on an empty ring answer at
// once; pop-before scans from the oldest record to the first match, refreshing if
// it removed the oldest and others remain; a range query sends its matches as it
// scans, then flushes the last one. Results are registered on their way out.
module timestamped_ring_buffer
    import trb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [OP_W-1:0]    opcode,
    input  logic [TIME_W-1:0]  key_time,
    input  logic [TIME_W-1:0]  range_end,
    input  logic [CAM_W-1:0]   camera_tag,
    input  logic [FRAME_W-1:0] frame_number,
    output logic               result_valid,
    output logic               found,
    output logic [TIME_W-1:0]  out_time,
    output logic [CAM_W-1:0]   out_camera,
    output logic [FRAME_W-1:0] out_frame,
    output logic               last,
    output logic [FILL_W-1:0]  fill_count,
    output logic [TIME_W-1:0]  oldest_time,
    output logic [TIME_W-1:0]  latest_time
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    cmd_t q_cmd;
    cmd_t q_head;

    trb_front u_front (
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .key_time     (key_time),
        .range_end    (range_end),
        .camera_tag   (camera_tag),
        .frame_number (frame_number),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (q_cmd)
    );

    trb_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head_cmd (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    trb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .found        (found),
        .out_time     (out_time),
        .out_camera   (out_camera),
        .out_frame    (out_frame),
        .last         (last),
        .fill_count   (fill_count),
        .oldest_time  (oldest_time),
        .latest_time  (latest_time)
    );

endmodule

>>> rtl/trb_checker.sv
`include "timestamped_ring_buffer_defines.svh"

module trb_checker
    import trb_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               result_valid,
    input logic               found,
    input logic [TIME_W-1:0]  out_time,
    input logic [CAM_W-1:0]   out_camera,
    input logic [FRAME_W-1:0] out_frame,
    input logic               last,
    input logic [FILL_W-1:0]  fill_count,
    input logic [TIME_W-1:0]  oldest_time,
    input logic [TIME_W-1:0]  latest_time
);

    // A miss carries an all-zero record
    `TRB_ASSERT_IMP(a_miss_zero, result_valid && !found, (out_time == '0) && (out_camera == '0) && (out_frame == '0), "miss result carries record data")

    // An empty ring reports zero end times
    `TRB_ASSERT_IMP(a_empty_times, result_valid && (fill_count == '0), (oldest_time == '0) && (latest_time == '0), "empty ring reports nonzero times")

    // Only range hits are followed by more results
    `TRB_ASSERT_NEVER(a_more_needs_hit, result_valid && !last && !found, "non-final result without a hit")

endmodule

bind timestamped_ring_buffer trb_checker u_trb_checker (.*);

>>> bench/timestamped_ring_buffer_test.sv
module timestamped_ring_buffer_test;
    import trb_pkg::*;

    localparam int  LIMIT_CYCLES = 200000;
    localparam int  SETTLE_CYCLES = 40;
    localparam op_t OP_SPARE_LO = 3'd6;
    localparam op_t OP_SPARE_HI = 3'd7;

    typedef struct packed {
        logic               found;
        logic [TIME_W-1:0]  tstamp;
        logic [CAM_W-1:0]   camera;
        logic [FRAME_W-1:0] frame;
        logic               last;
        logic [FILL_W-1:0]  fill;
        logic [TIME_W-1:0]  oldest;
        logic [TIME_W-1:0]  latest;
    } frame_result_t;

    // Ring predictor and store of the results each request should produce
    class ring_scoreboard;
        logic [TIME_W-1:0]  slot_time [CAPACITY];
        logic [CAM_W-1:0]   slot_camera [CAPACITY];
        logic [FRAME_W-1:0] slot_frame [CAPACITY];
        int unsigned        head = 0;
        int unsigned        tail = 0;
        int unsigned        count = 0;
        frame_result_t      due_results[$];
        int unsigned        errors = 0;

        function int unsigned step_up(int unsigned i);
            return (i + 1) % CAPACITY;
        endfunction

        function int unsigned step_down(int unsigned i);
            return (i + CAPACITY - 1) % CAPACITY;
        endfunction

        // Queue one result, stamping the ring status as it stands now
        function void expect_result(logic f, logic [TIME_W-1:0] t, logic [CAM_W-1:0] cam,
                                    logic [FRAME_W-1:0] frm, logic lst);
            frame_result_t r;
            r.found  = f;
            r.tstamp = t;
            r.camera = cam;
            r.frame  = frm;
            r.last   = lst;
            r.fill   = FILL_W'(count);
            r.oldest = (count != 0) ? slot_time[tail] : '0;
            r.latest = (count != 0) ? slot_time[step_down(head)] : '0;
            due_results = {due_results, r};
        endfunction

        function void note_request(op_t op, logic [TIME_W-1:0] key, logic [TIME_W-1:0] rend,
                                   logic [CAM_W-1:0] cam, logic [FRAME_W-1:0] frm);
            op_t           kind;
            int unsigned   idx;
            int unsigned   hits[$];
            logic          matched;
            kind = op;
            matched = 1'b0;
            // A zero bound takes the oldest record
            if (op == OP_POP_BEFORE && key == '0)
                kind = OP_POP_OLDEST;
            case (kind)
                OP_PUSH:
                begin
                    slot_time[head] = key;
                    slot_camera[head] = cam;
                    slot_frame[head] = frm;
                    head = step_up(head);
                    if (count < CAPACITY)
                        count++;
                    else
                        tail = step_up(tail);
                    expect_result(1'b1, '0, '0, '0, 1'b1);
                end
                OP_POP_OLDEST:
                begin
                    if (count == 0)
                        expect_result(1'b0, '0, '0, '0, 1'b1);
                    else
                    begin
                        idx = tail;
                        tail = step_up(tail);
                        count--;
                        expect_result(1'b1, slot_time[idx], slot_camera[idx], slot_frame[idx],
                                      1'b1);
                    end
                end
                OP_POP_BEFORE:
                begin
                    // Scan from the oldest; remove the match only when it is the oldest
                    idx = tail;
                    for (int unsigned i = 0; i < count && !matched; i++)
                    begin
                        if (slot_time[idx] <= key)
                        begin
                            matched = 1'b1;
                            if (i == 0)
                            begin
                                tail = step_up(tail);
                                count--;
                            end
                            expect_result(1'b1, slot_time[idx], slot_camera[idx],
                                          slot_frame[idx], 1'b1);
                        end
                        idx = step_up(idx);
                    end
                    if (!matched)
                        expect_result(1'b0, '0, '0, '0, 1'b1);
                end
                OP_POP_LATEST:
                begin
                    if (count == 0)
                        expect_result(1'b0, '0, '0, '0, 1'b1);
                    else
                    begin
                        idx = step_down(head);
                        head = idx;
                        count--;
                        expect_result(1'b1, slot_time[idx], slot_camera[idx], slot_frame[idx],
                                      1'b1);
                    end
                end
                OP_RANGE:
                begin
                    idx = tail;
                    for (int unsigned i = 0; i < count; i++)
                    begin
                        if (slot_time[idx] >= key && slot_time[idx] <= rend)
                            hits = {hits, idx};
                        idx = step_up(idx);
                    end
                    if (hits.size() == 0)
                        expect_result(1'b0, '0, '0, '0, 1'b1);
                    foreach (hits[k])
                        expect_result(1'b1, slot_time[hits[k]], slot_camera[hits[k]],
                                      slot_frame[hits[k]], k == hits.size() - 1);
                end
                OP_CLEAR:
                begin
                    head = 0;
                    tail = 0;
                    count = 0;
                    expect_result(1'b1, '0, '0, '0, 1'b1);
                end
                default:
                    expect_result(1'b0, '0, '0, '0, 1'b1);
            endcase
        endfunction

        function void check_result(frame_result_t seen);
            frame_result_t want;
            if (due_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: found=%0b time=%0h last=%0b fill=%0d",
                             seen.found, seen.tstamp, seen.last, seen.fill);
                return;
            end
            want = due_results.pop_front();
            if (seen !== want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("result mismatch at %0t", $time);
                    $display("  expected found=%0b time=%0h cam=%0h frame=%0h last=%0b",
                             want.found, want.tstamp, want.camera, want.frame, want.last);
                    $display("           fill=%0d oldest=%0h latest=%0h",
                             want.fill, want.oldest, want.latest);
                    $display("  actual   found=%0b time=%0h cam=%0h frame=%0h last=%0b",
                             seen.found, seen.tstamp, seen.camera, seen.frame, seen.last);
                    $display("           fill=%0d oldest=%0h latest=%0h",
                             seen.fill, seen.oldest, seen.latest);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [OP_W-1:0]    opcode;
    logic [TIME_W-1:0]  key_time;
    logic [TIME_W-1:0]  range_end;
    logic [CAM_W-1:0]   camera_tag;
    logic [FRAME_W-1:0] frame_number;
    logic               result_valid;
    logic               found;
    logic [TIME_W-1:0]  out_time;
    logic [CAM_W-1:0]   out_camera;
    logic [FRAME_W-1:0] out_frame;
    logic               last;
    logic [FILL_W-1:0]  fill_count;
    logic [TIME_W-1:0]  oldest_time;
    logic [TIME_W-1:0]  latest_time;

    ring_scoreboard     sb;
    logic [TIME_W-1:0]  capture_clock;
    int unsigned        cycle_count;
    int unsigned        total_errors;

    timestamped_ring_buffer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .key_time     (key_time),
        .range_end    (range_end),
        .camera_tag   (camera_tag),
        .frame_number (frame_number),
        .result_valid (result_valid),
        .found        (found),
        .out_time     (out_time),
        .out_camera   (out_camera),
        .out_frame    (out_frame),
        .last         (last),
        .fill_count   (fill_count),
        .oldest_time  (oldest_time),
        .latest_time  (latest_time)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Check every result in the cycle it shows
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            sb.check_result(frame_result_t'{found, out_time, out_camera, out_frame, last,
                                            fill_count, oldest_time, latest_time});
    end

    function automatic logic [TIME_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [TIME_W-1:0] back_off(logic [TIME_W-1:0] t, int unsigned d);
        return (t < d) ? '0 : t - d;
    endfunction

    // Offer one request, idling first at the given rate, and note it once taken
    task automatic send_request(op_t op, logic [TIME_W-1:0] key, logic [TIME_W-1:0] rend,
                                logic [CAM_W-1:0] cam, logic [FRAME_W-1:0] frm,
                                int unsigned idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        start <= 1'b1;
        opcode <= op;
        key_time <= key;
        range_end <= rend;
        camera_tag <= cam;
        frame_number <= frm;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_request(op, key, rend, cam, frm);
    endtask

    // Hold off until the block has answered everything
    task automatic drain();
        start <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
    endtask

    // Build a mostly well-formed request around the running capture clock
    task automatic random_request(int unsigned push_pct, int unsigned idle_pct);
        op_t               op;
        int unsigned       pick;
        logic [TIME_W-1:0] key;
        logic [TIME_W-1:0] rend;
        key = rand64();
        rend = rand64();
        if ($urandom_range(0, 99) < push_pct)
            op = OP_PUSH;
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
                op = OP_POP_OLDEST;
            else if (pick < 35)
                op = OP_POP_BEFORE;
            else if (pick < 48)
                op = OP_POP_LATEST;
            else if (pick < 85)
                op = OP_RANGE;
            else if (pick < 92)
                op = OP_CLEAR;
            else if (pick < 96)
                op = OP_SPARE_LO;
            else
                op = OP_SPARE_HI;
        end
        case (op)
            OP_PUSH:
            begin
                capture_clock = capture_clock + $urandom_range(0, 50);
                if ($urandom_range(0, 9) != 0)
                    key = capture_clock;
            end
            OP_POP_BEFORE:
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    key = '0;
                else if (pick > 1)
                    key = back_off(capture_clock, $urandom_range(0, 300));
            end
            OP_RANGE:
            begin
                if ($urandom_range(0, 9) != 0)
                begin
                    key = back_off(capture_clock, $urandom_range(0, 600));
                    rend = key + $urandom_range(0, 400);
                end
            end
            default:
            begin
            end
        endcase
        send_request(op, key, rend, CAM_W'($urandom), $urandom, idle_pct);
    endtask

    initial
    begin
        sb = new();
        cycle_count = 0;
        capture_clock = 64'd1000;
        rst_n <= 1'b0;
        start <= 1'b0;
        opcode <= OP_PUSH;
        key_time <= '0;
        range_end <= '0;
        camera_tag <= '0;
        frame_number <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty ring, extremes, every pop flavor, range edges, spare opcodes
        send_request(OP_POP_OLDEST, '0, '0, '0, '0, 0);
        send_request(OP_POP_LATEST, '0, '0, '0, '0, 0);
        send_request(OP_POP_BEFORE, 64'd5, '0, '0, '0, 0);
        send_request(OP_RANGE, '0, '1, '0, '0, 0);
        send_request(OP_PUSH, '0, '0, '0, '0, 0);
        send_request(OP_PUSH, '1, '1, '1, '1, 0);
        send_request(OP_PUSH, 64'd100, '0, 16'h1234, 32'd7, 0);
        send_request(OP_PUSH, 64'd50, '0, 16'h8001, 32'h8000_0001, 0);
        send_request(OP_POP_BEFORE, 64'd60, '0, '0, '0, 0);
        send_request(OP_POP_BEFORE, 64'd60, '0, '0, '0, 0);
        send_request(OP_POP_BEFORE, 64'd10, '0, '0, '0, 0);
        send_request(OP_POP_BEFORE, '1, '0, '0, '0, 0);
        send_request(OP_POP_BEFORE, '0, '0, '0, '0, 0);
        send_request(OP_RANGE, '0, '1, '0, '0, 0);
        send_request(OP_RANGE, 64'd60, 64'd99, '0, '0, 0);
        send_request(OP_RANGE, 64'd200, 64'd100, '0, '0, 0);
        send_request(OP_RANGE, '1, '1, '0, '0, 0);
        send_request(OP_POP_LATEST, '0, '0, '0, '0, 0);
        send_request(OP_SPARE_LO, '0, '0, '0, '0, 0);
        send_request(OP_SPARE_HI, '1, '1, '1, '1, 0);
        send_request(OP_CLEAR, '0, '0, '0, '0, 0);
        send_request(OP_POP_LATEST, '0, '0, '0, '0, 0);
        send_request(OP_PUSH, 64'd7, '0, 16'h00ff, 32'h0000_ffff, 0);
        send_request(OP_RANGE, 64'd7, 64'd7, '0, '0, 0);

        // Random: back to back, push heavy so the ring wraps and overwrites
        repeat (38) random_request(75, 0);
        drain();
        // Sender idles often
        repeat (38) random_request(45, 56);
        drain();
        // Sender idles at a lower rate
        repeat (38) random_request(50, 34);
        drain();
        // Back to back again
        repeat (32) random_request(60, 0);
        drain();

        repeat (SETTLE_CYCLES) @(posedge clk);
        total_errors = sb.errors + sb.due_results.size();
        if (total_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
